>>> rtl/ersgdm_pkg.sv
`timescale 1ns / 1ps
// shared types, widths, register indexes and reset values of the momentum sgd rate update
// no dependencies; every other file of the block uses it by scoped names

package ersgdm_pkg;

  localparam int USERS      = 4096;
  localparam int UIDX_W     = $clog2(USERS);
  localparam int UID_W      = 12;
  localparam int RATE_W     = 32;
  localparam int VEL_W      = 40;
  localparam int ERR_W      = 34;
  localparam int LR_W       = 24;
  localparam int MOM_W      = 16;
  localparam int OPW        = 42;
  localparam int DIV_STEPS  = 33;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LR_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LR_USER    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_FLOOR = 2'd3;

  localparam logic [LR_W-1:0]   LR_BASE_RST    = 24'd16777;
  localparam logic [LR_W-1:0]   LR_USER_RST    = 24'd16777;
  localparam logic [MOM_W-1:0]  MOMENTUM_RST   = 16'd58982;
  localparam logic [RATE_W-1:0] RATE_FLOOR_RST = 32'd66;

  localparam logic signed [OPW-1:0] RATE_MAX = OPW'({RATE_W{1'b1}});
  localparam logic signed [OPW-1:0] VEL_MAX  = 42'sd549755813887;
  localparam logic signed [OPW-1:0] VEL_MIN  = -42'sd549755813888;

  typedef enum logic [2:0] {
    OP_ADD_SAT,
    OP_SUB_SAT,
    OP_DIV_STEP,
    OP_MUL_MOM,
    OP_MUL_LR,
    OP_RATE
  } alu_op_t;

  typedef struct packed {
    alu_op_t                 op;
    logic signed [OPW-1:0]   a;
    logic signed [OPW-1:0]   b;
    logic [RATE_W-1:0]       floor_val;
    logic                    cin;
  } alu_req_t;

  typedef struct packed {
    logic signed [OPW-1:0]   res;
    logic                    flag;
  } alu_rsp_t;

  typedef struct packed {
    logic                    seen;
    logic signed [VEL_W-1:0] vel;
    logic [RATE_W-1:0]       rate;
  } user_row_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DEN,
    S_DIV,
    S_ERR,
    S_MBV,
    S_MBE,
    S_SBV,
    S_MUV,
    S_MUE,
    S_SUV,
    S_RB,
    S_RU,
    S_WB,
    S_DONE
  } state_t;

endpackage

>>> rtl/ersgdm_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for samples in and updated rates out
// depends on ersgdm_pkg for the field widths

interface ersgdm_in_if;
  logic                                valid;
  logic                                ready;
  logic [ersgdm_pkg::UID_W-1:0]        user_index;
  logic [ersgdm_pkg::RATE_W-1:0]       gap_hours;

  modport source (output valid, output user_index, output gap_hours, input ready);
  modport sink   (input valid, input user_index, input gap_hours, output ready);
endinterface

interface ersgdm_out_if;
  logic                                valid;
  logic                                ready;
  logic [ersgdm_pkg::UID_W-1:0]        user_index_out;
  logic [ersgdm_pkg::RATE_W-1:0]       user_rate;
  logic [ersgdm_pkg::RATE_W-1:0]       base_rate;
  logic                                saturated;

  modport source (output valid, output user_index_out, output user_rate, output base_rate,
                  output saturated, input ready);
  modport sink   (input valid, input user_index_out, input user_rate, input base_rate,
                  input saturated, output ready);
endinterface

>>> rtl/ersgdm_user_mem.sv
`timescale 1ns / 1ps
// per-user table: seen flag, velocity and rate in one row, one write and one read port
// depends on ersgdm_pkg for the row type and depth

module ersgdm_user_mem (
  input  logic                           clk,
  input  logic                           we,
  input  logic [ersgdm_pkg::UIDX_W-1:0]  waddr,
  input  ersgdm_pkg::user_row_t          wdata,
  input  logic                           re,
  input  logic [ersgdm_pkg::UIDX_W-1:0]  raddr,
  output ersgdm_pkg::user_row_t          rdata_r
);

  ersgdm_pkg::user_row_t mem_r [ersgdm_pkg::USERS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

>>> rtl/ersgdm_alu.sv
`timescale 1ns / 1ps
// shared arithmetic unit: saturating add/sub, one restoring divide step,
// scaled multiply and floored rate update; depends on ersgdm_pkg

module ersgdm_alu (
  input  ersgdm_pkg::alu_req_t req,
  output ersgdm_pkg::alu_rsp_t rsp
);

  logic signed [ersgdm_pkg::OPW-1:0]    sum;
  logic signed [ersgdm_pkg::OPW-1:0]    diff;
  logic signed [40:0]                   mx;
  logic signed [24:0]                   my;
  logic signed [65:0]                   prod;
  logic [32:0]                          trial;
  logic [32:0]                          dvs;
  logic [32:0]                          rq;
  logic                                 ge;
  logic [ersgdm_pkg::RATE_W-1:0]        rclip;

  always_comb begin
    sum   = req.a + req.b;
    diff  = req.a - req.b;
    mx    = req.a[40:0];
    my    = {1'b0, req.b[ersgdm_pkg::LR_W-1:0]};
    prod  = mx * my;
    trial = {req.a[31:0], req.cin};
    dvs   = {1'b0, req.b[31:0]};
    ge    = (trial >= dvs);
    rq    = ge ? (trial - dvs) : trial;

    if (sum > ersgdm_pkg::RATE_MAX) begin
      rclip = '1;
    end else if (sum < 0) begin
      rclip = '0;
    end else begin
      rclip = sum[ersgdm_pkg::RATE_W-1:0];
    end

    rsp.res  = '0;
    rsp.flag = 1'b0;
    case (req.op)
      ersgdm_pkg::OP_ADD_SAT: begin
        if (sum > ersgdm_pkg::RATE_MAX) begin
          rsp.res  = ersgdm_pkg::RATE_MAX;
          rsp.flag = 1'b1;
        end else begin
          rsp.res  = sum;
        end
      end
      ersgdm_pkg::OP_SUB_SAT: begin
        if (diff > ersgdm_pkg::VEL_MAX) begin
          rsp.res  = ersgdm_pkg::VEL_MAX;
          rsp.flag = 1'b1;
        end else if (diff < ersgdm_pkg::VEL_MIN) begin
          rsp.res  = ersgdm_pkg::VEL_MIN;
          rsp.flag = 1'b1;
        end else begin
          rsp.res  = diff;
        end
      end
      ersgdm_pkg::OP_DIV_STEP: begin
        // flag carries the quotient bit
        rsp.res  = {{(ersgdm_pkg::OPW-33){1'b0}}, rq};
        rsp.flag = ge;
      end
      ersgdm_pkg::OP_MUL_MOM: begin
        rsp.res = ersgdm_pkg::OPW'(prod >>> 16);
      end
      ersgdm_pkg::OP_MUL_LR: begin
        rsp.res = ersgdm_pkg::OPW'(prod >>> 24);
      end
      ersgdm_pkg::OP_RATE: begin
        rsp.flag = (sum > ersgdm_pkg::RATE_MAX);
        if (rclip < req.floor_val) begin
          rsp.res = ersgdm_pkg::OPW'(req.floor_val);
        end else begin
          rsp.res = ersgdm_pkg::OPW'(rclip);
        end
      end
      default: begin
        rsp.res  = '0;
        rsp.flag = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/exp_rate_sgd_momentum_update.sv
`timescale 1ns / 1ps
// momentum sgd step of a per-user exponential rate model, one sample at a time
// a new sample is taken only after the previous one has been through the 33-step bit-serial
// reciprocal on the shared arithmetic unit and the multiply and update steps around it, and
// after its result has been loaded into the output register, which waits on out_ch.ready
// reset: synchronous, active low; afterwards a clearing pass over all USERS (4096) rows
// empties the user table before the first sample is taken

module exp_rate_sgd_momentum_update (
  input  logic                               clk,
  input  logic                               rst_n,
  ersgdm_in_if.sink                          in_ch,
  ersgdm_out_if.source                       out_ch,
  input  logic                               cfg_we,
  input  logic [ersgdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ersgdm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int RW = ersgdm_pkg::RATE_W;
  localparam int VW = ersgdm_pkg::VEL_W;
  localparam int EW = ersgdm_pkg::ERR_W;
  localparam int OW = ersgdm_pkg::OPW;

  ersgdm_pkg::state_t state_r, state_nxt;

  logic [ersgdm_pkg::LR_W-1:0]    lr_base_r;
  logic [ersgdm_pkg::LR_W-1:0]    lr_user_r;
  logic [ersgdm_pkg::MOM_W-1:0]   momentum_r;
  logic [RW-1:0]                  rate_floor_r;

  logic [RW-1:0]                  brate_r;
  logic signed [VW-1:0]           bvel_r;
  logic [RW-1:0]                  urate_r;
  logic signed [VW-1:0]           uvel_r;
  logic [ersgdm_pkg::UID_W-1:0]   uid_r;
  logic [ersgdm_pkg::UIDX_W-1:0]  uaddr_r;
  logic [RW-1:0]                  gap_r;
  logic [RW-1:0]                  den_r;
  logic [RW-1:0]                  rem_r;
  logic [RW:0]                    quo_r;
  logic signed [EW-1:0]           err_r;
  logic signed [VW-1:0]           acc_r;
  logic signed [EW-1:0]           prod_r;
  logic                           sat_r;
  logic [ersgdm_pkg::CNT_W-1:0]   cnt_r;
  logic [ersgdm_pkg::UIDX_W-1:0]  clr_addr_r;

  logic                           out_valid_r, out_valid_nxt;
  logic [ersgdm_pkg::UID_W-1:0]   out_uid_r;
  logic [RW-1:0]                  out_urate_r;
  logic [RW-1:0]                  out_brate_r;
  logic                           out_sat_r;

  logic                           in_take;
  logic                           out_load;
  logic [ersgdm_pkg::UIDX_W-1:0]  in_addr;
  logic [RW-1:0]                  recip;
  logic                           mem_we;
  logic [ersgdm_pkg::UIDX_W-1:0]  mem_waddr;
  ersgdm_pkg::user_row_t          mem_wdata;
  ersgdm_pkg::user_row_t          mem_rdata;
  ersgdm_pkg::alu_req_t           alu_req;
  ersgdm_pkg::alu_rsp_t           alu_rsp;

  assign in_addr = ersgdm_pkg::UIDX_W'(in_ch.user_index % ersgdm_pkg::USERS);
  assign in_take = in_ch.valid && in_ch.ready;
  assign recip   = quo_r[RW] ? '1 : quo_r[RW-1:0];

  ersgdm_user_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (in_take),
    .raddr   (in_addr),
    .rdata_r (mem_rdata)
  );

  ersgdm_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_base_r    <= ersgdm_pkg::LR_BASE_RST;
      lr_user_r    <= ersgdm_pkg::LR_USER_RST;
      momentum_r   <= ersgdm_pkg::MOMENTUM_RST;
      rate_floor_r <= ersgdm_pkg::RATE_FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ersgdm_pkg::CFG_LR_BASE:    lr_base_r    <= cfg_data[ersgdm_pkg::LR_W-1:0];
        ersgdm_pkg::CFG_LR_USER:    lr_user_r    <= cfg_data[ersgdm_pkg::LR_W-1:0];
        ersgdm_pkg::CFG_MOMENTUM:   momentum_r   <= cfg_data[ersgdm_pkg::MOM_W-1:0];
        ersgdm_pkg::CFG_RATE_FLOOR: rate_floor_r <= cfg_data[RW-1:0];
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ersgdm_pkg::S_CLEAR: begin
        if (clr_addr_r == ersgdm_pkg::UIDX_W'(ersgdm_pkg::USERS - 1)) begin
          state_nxt = ersgdm_pkg::S_IDLE;
        end
      end
      ersgdm_pkg::S_IDLE:  if (in_ch.valid) state_nxt = ersgdm_pkg::S_READ;
      ersgdm_pkg::S_READ:  state_nxt = ersgdm_pkg::S_DEN;
      ersgdm_pkg::S_DEN:   state_nxt = ersgdm_pkg::S_DIV;
      ersgdm_pkg::S_DIV:   if (cnt_r == '0) state_nxt = ersgdm_pkg::S_ERR;
      ersgdm_pkg::S_ERR:   state_nxt = ersgdm_pkg::S_MBV;
      ersgdm_pkg::S_MBV:   state_nxt = ersgdm_pkg::S_MBE;
      ersgdm_pkg::S_MBE:   state_nxt = ersgdm_pkg::S_SBV;
      ersgdm_pkg::S_SBV:   state_nxt = ersgdm_pkg::S_MUV;
      ersgdm_pkg::S_MUV:   state_nxt = ersgdm_pkg::S_MUE;
      ersgdm_pkg::S_MUE:   state_nxt = ersgdm_pkg::S_SUV;
      ersgdm_pkg::S_SUV:   state_nxt = ersgdm_pkg::S_RB;
      ersgdm_pkg::S_RB:    state_nxt = ersgdm_pkg::S_RU;
      ersgdm_pkg::S_RU:    state_nxt = ersgdm_pkg::S_WB;
      ersgdm_pkg::S_WB:    state_nxt = ersgdm_pkg::S_DONE;
      ersgdm_pkg::S_DONE:  if (!out_valid_r || out_ch.ready) state_nxt = ersgdm_pkg::S_IDLE;
      default:             state_nxt = ersgdm_pkg::S_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready       = 1'b0;
    out_load          = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = uaddr_r;
    mem_wdata         = '{seen: 1'b1, vel: uvel_r, rate: urate_r};
    alu_req.op        = ersgdm_pkg::OP_ADD_SAT;
    alu_req.a         = '0;
    alu_req.b         = '0;
    alu_req.floor_val = rate_floor_r;
    alu_req.cin       = 1'b0;
    case (state_r)
      ersgdm_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
      end
      ersgdm_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ersgdm_pkg::S_DEN: begin
        alu_req.op = ersgdm_pkg::OP_ADD_SAT;
        alu_req.a  = OW'(urate_r);
        alu_req.b  = OW'(brate_r);
      end
      ersgdm_pkg::S_DIV: begin
        // the dividend 2^32 has its single one in the first step
        alu_req.op  = ersgdm_pkg::OP_DIV_STEP;
        alu_req.a   = OW'(rem_r);
        alu_req.b   = OW'(den_r);
        alu_req.cin = (cnt_r == ersgdm_pkg::CNT_W'(ersgdm_pkg::DIV_STEPS - 1));
      end
      ersgdm_pkg::S_ERR: begin
        alu_req.op = ersgdm_pkg::OP_SUB_SAT;
        alu_req.a  = OW'(gap_r);
        alu_req.b  = OW'(recip);
      end
      ersgdm_pkg::S_MBV: begin
        alu_req.op = ersgdm_pkg::OP_MUL_MOM;
        alu_req.a  = OW'(bvel_r);
        alu_req.b  = OW'(momentum_r);
      end
      ersgdm_pkg::S_MBE: begin
        alu_req.op = ersgdm_pkg::OP_MUL_LR;
        alu_req.a  = OW'(err_r);
        alu_req.b  = OW'(lr_base_r);
      end
      ersgdm_pkg::S_SBV, ersgdm_pkg::S_SUV: begin
        alu_req.op = ersgdm_pkg::OP_SUB_SAT;
        alu_req.a  = OW'(acc_r);
        alu_req.b  = OW'(prod_r);
      end
      ersgdm_pkg::S_MUV: begin
        alu_req.op = ersgdm_pkg::OP_MUL_MOM;
        alu_req.a  = OW'(uvel_r);
        alu_req.b  = OW'(momentum_r);
      end
      ersgdm_pkg::S_MUE: begin
        alu_req.op = ersgdm_pkg::OP_MUL_LR;
        alu_req.a  = OW'(err_r);
        alu_req.b  = OW'(lr_user_r);
      end
      ersgdm_pkg::S_RB: begin
        alu_req.op = ersgdm_pkg::OP_RATE;
        alu_req.a  = OW'(brate_r);
        alu_req.b  = OW'(bvel_r);
      end
      ersgdm_pkg::S_RU: begin
        alu_req.op = ersgdm_pkg::OP_RATE;
        alu_req.a  = OW'(urate_r);
        alu_req.b  = OW'(uvel_r);
      end
      ersgdm_pkg::S_WB: begin
        mem_we = 1'b1;
      end
      ersgdm_pkg::S_DONE: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state and the shared base model
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ersgdm_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
      clr_addr_r  <= '0;
      cnt_r       <= '0;
      brate_r     <= '0;
      bvel_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ersgdm_pkg::S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (state_r == ersgdm_pkg::S_DEN) begin
        cnt_r <= ersgdm_pkg::CNT_W'(ersgdm_pkg::DIV_STEPS - 1);
      end else if (state_r == ersgdm_pkg::S_DIV) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (state_r == ersgdm_pkg::S_SBV) begin
        bvel_r <= alu_rsp.res[VW-1:0];
      end
      if (state_r == ersgdm_pkg::S_RB) begin
        brate_r <= alu_rsp.res[RW-1:0];
      end
    end
  end

  // per-sample datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ersgdm_pkg::S_IDLE: begin
        if (in_take) begin
          uid_r   <= in_ch.user_index;
          gap_r   <= in_ch.gap_hours;
          uaddr_r <= in_addr;
          sat_r   <= 1'b0;
        end
      end
      ersgdm_pkg::S_READ: begin
        // a user not seen before starts at the floor with no velocity
        if (mem_rdata.seen) begin
          urate_r <= mem_rdata.rate;
          uvel_r  <= mem_rdata.vel;
        end else begin
          urate_r <= rate_floor_r;
          uvel_r  <= '0;
        end
      end
      ersgdm_pkg::S_DEN: begin
        den_r <= alu_rsp.res[RW-1:0];
        rem_r <= '0;
        sat_r <= sat_r | alu_rsp.flag;
      end
      ersgdm_pkg::S_DIV: begin
        rem_r <= alu_rsp.res[RW-1:0];
        quo_r <= {quo_r[RW-1:0], alu_rsp.flag};
      end
      ersgdm_pkg::S_ERR: begin
        err_r <= alu_rsp.res[EW-1:0];
        sat_r <= sat_r | quo_r[RW];
      end
      ersgdm_pkg::S_MBV, ersgdm_pkg::S_MUV: begin
        acc_r <= alu_rsp.res[VW-1:0];
      end
      ersgdm_pkg::S_MBE, ersgdm_pkg::S_MUE: begin
        prod_r <= alu_rsp.res[EW-1:0];
      end
      ersgdm_pkg::S_SBV, ersgdm_pkg::S_RB: begin
        sat_r <= sat_r | alu_rsp.flag;
      end
      ersgdm_pkg::S_SUV: begin
        uvel_r <= alu_rsp.res[VW-1:0];
        sat_r  <= sat_r | alu_rsp.flag;
      end
      ersgdm_pkg::S_RU: begin
        urate_r <= alu_rsp.res[RW-1:0];
        sat_r   <= sat_r | alu_rsp.flag;
      end
      ersgdm_pkg::S_DONE: begin
        if (out_load) begin
          out_uid_r   <= uid_r;
          out_urate_r <= urate_r;
          out_brate_r <= brate_r;
          out_sat_r   <= sat_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.user_index_out = out_uid_r;
  assign out_ch.user_rate      = out_urate_r;
  assign out_ch.base_rate      = out_brate_r;
  assign out_ch.saturated      = out_sat_r;

`ifndef SYNTH
  // restoring division keeps the partial remainder below the divisor
  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ersgdm_pkg::S_DIV && den_r != '0) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

  a_base_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ersgdm_pkg::S_RB) |=> (brate_r >= rate_floor_r))
    else $error("base rate below floor after update");

  a_user_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ersgdm_pkg::S_RU) |=> (urate_r >= rate_floor_r))
    else $error("user rate below floor after update");

  // a result is only loaded once the previous one has gone
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !out_load)
    else $error("pending result overwritten");
`endif

endmodule
